[hdl/sfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared widths and constants of the serial frame receiver with sum check.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned FRAME_LEN_DEF = 8;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned POS_W         = 5;
  localparam int unsigned IDX_W         = 5;

  localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hA3;
  localparam logic [BYTE_W-1:0] TYPE_MIN    = 8'h01;
  localparam logic [BYTE_W-1:0] TYPE_MAX    = 8'h03;

  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

endpackage

[hdl/sfr_rx_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_rx_if
// Received byte channel: valid, ready and one serial byte per item.
// ----------------------------------------------------------------------------
interface sfr_rx_if;
  import sfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[hdl/sfr_res_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_res_if
// Result channel: status items and payload items of good frames.
// ----------------------------------------------------------------------------
interface sfr_res_if;
  import sfr_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] running_sum;
  logic [IDX_W-1:0]  payload_index;
  logic [BYTE_W-1:0] payload_byte;
  logic              frame_good;
  logic              last;

  modport source (output valid, output kind, output running_sum, output payload_index,
                  output payload_byte, output frame_good, output last, input ready);
  modport sink   (input valid, input kind, input running_sum, input payload_index,
                  input payload_byte, input frame_good, input last, output ready);
endinterface

[hdl/serial_frame_receiver_sum_check_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_receiver_sum_check_unit
// Frame parser for header, type, payload and 8-bit additive checksum bytes.
// Payload bytes go to a RAM and are replayed after a matching checksum.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                              | role
//  rx      | in  | rx_byte                                              | serial bytes
//  res     | out | kind running_sum payload_index payload_byte          | status and
//          |     | frame_good last                                      | payload items
//
//  a byte that ends no good frame: once it is accepted, its status item
//  sits in the output register on the next cycle
//  a matching checksum byte: ST_RD reads each payload byte from the RAM (read
//  data registered), ST_OUT loads it into the output register once it is free
//  rx is taken only in idle with the output register free or draining
//  rst is synchronous; position and sum clear, the RAM keeps its contents
// ----------------------------------------------------------------------------
module serial_frame_receiver_sum_check_unit #(
  parameter int unsigned FRAME_LEN = sfr_pkg::FRAME_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sfr_rx_if.sink    rx,
  sfr_res_if.source res
);
  import sfr_pkg::*;

  localparam int unsigned PAYLOAD_LEN = FRAME_LEN - 3;
  localparam int unsigned AW          = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;
  localparam logic [1:0] ST_STAT = 2'd3;

  logic [1:0]        state;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_next;
  logic [BYTE_W-1:0] sum;
  logic [BYTE_W-1:0] sum_next;
  logic [AW-1:0]     idx;
  logic              good;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic              out_free;
  logic              rx_fire;
  logic              o_load;

  logic              o_valid;
  logic              o_kind;
  logic [BYTE_W-1:0] o_sum;
  logic [IDX_W-1:0]  o_index;
  logic [BYTE_W-1:0] o_byte;
  logic              o_good;
  logic              o_last;

  sfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PAYLOAD_LEN)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (rx.rx_byte),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign out_free  = !o_valid || res.ready;
  assign rx.ready  = (state == ST_IDLE) && out_free;
  assign rx_fire   = rx.valid && rx.ready;
  assign ram_waddr = AW'(pos - POS_W'(2));
  assign o_load    = ((state == ST_IDLE) && rx_fire && !good)
                  || (((state == ST_OUT) || (state == ST_STAT)) && out_free);

  always_comb begin
    pos_next = pos;
    sum_next = sum;
    good     = 1'b0;
    ram_we   = 1'b0;
    if (pos == POS_W'(0)) begin
      if (rx.rx_byte == HEADER_BYTE) begin
        sum_next = sum + rx.rx_byte;
        pos_next = POS_W'(1);
      end
    end else if (pos == POS_W'(1)) begin
      if (rx.rx_byte inside {[TYPE_MIN:TYPE_MAX]}) begin
        sum_next = sum + rx.rx_byte;
        pos_next = POS_W'(2);
      end else begin
        sum_next = '0;
        pos_next = '0;
      end
    end else if (pos == POS_W'(FRAME_LEN - 1)) begin
      good     = (rx.rx_byte == sum);
      sum_next = '0;
      pos_next = '0;
    end else begin
      ram_we   = rx_fire;
      sum_next = sum + rx.rx_byte;
      pos_next = pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pos     <= '0;
      sum     <= '0;
      idx     <= '0;
      o_valid <= 1'b0;
    end else begin
      if (res.ready && !o_load) begin
        o_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (rx_fire) begin
            pos <= pos_next;
            sum <= sum_next;
            if (good) begin
              idx   <= '0;
              state <= ST_RD;
            end else begin
              o_valid <= 1'b1;
              o_kind  <= KIND_STATUS;
              o_sum   <= sum_next;
              o_index <= '0;
              o_byte  <= '0;
              o_good  <= 1'b0;
              o_last  <= 1'b1;
            end
          end
        end
        ST_RD: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            o_valid <= 1'b1;
            o_kind  <= KIND_PAYLOAD;
            o_sum   <= sum;
            o_index <= IDX_W'(idx);
            o_byte  <= ram_rdata;
            o_good  <= 1'b0;
            o_last  <= 1'b0;
            if (idx == AW'(PAYLOAD_LEN - 1)) begin
              state <= ST_STAT;
            end else begin
              idx   <= idx + AW'(1);
              state <= ST_RD;
            end
          end
        end
        ST_STAT: begin
          if (out_free) begin
            o_valid <= 1'b1;
            o_kind  <= KIND_STATUS;
            o_sum   <= sum;
            o_index <= '0;
            o_byte  <= '0;
            o_good  <= 1'b1;
            o_last  <= 1'b1;
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign res.valid         = o_valid;
  assign res.kind          = o_kind;
  assign res.running_sum   = o_sum;
  assign res.payload_index = o_index;
  assign res.payload_byte  = o_byte;
  assign res.frame_good    = o_good;
  assign res.last          = o_last;

endmodule

[hdl/sfr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 5
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/sfr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module sfr_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      rx_ready,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic                      kind,
  input logic [sfr_pkg::BYTE_W-1:0] running_sum,
  input logic [sfr_pkg::IDX_W-1:0]  payload_index,
  input logic [sfr_pkg::BYTE_W-1:0] payload_byte,
  input logic                      frame_good,
  input logic                      last
);
  import sfr_pkg::*;

  // stalled item holds
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(payload_byte) && $stable(payload_index)
      && $stable(kind) && $stable(last))
    else $error("stalled result item changed");

  // no new byte taken while a result is stuck
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !rx_ready)
    else $error("rx ready while result stalled");

  // payload items never end a byte, never flag a good frame and carry a cleared sum
  assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_PAYLOAD |-> !last && !frame_good && running_sum == '0)
    else $error("bad payload item fields");

  // a good frame status item closes the burst with a cleared sum
  assert property (@(posedge clk) disable iff (rst)
    res_valid && frame_good |-> last && kind == KIND_STATUS && running_sum == '0
      && payload_index == '0)
    else $error("bad good-frame status item");

endmodule

bind serial_frame_receiver_sum_check_unit sfr_checker u_sfr_checker (
  .clk           (clk),
  .rst           (rst),
  .rx_ready      (rx.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .kind          (res.kind),
  .running_sum   (res.running_sum),
  .payload_index (res.payload_index),
  .payload_byte  (res.payload_byte),
  .frame_good    (res.frame_good),
  .last          (res.last)
);

[dv/sfr_frame_check_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_frame_check_pkg
// Byte-level frame parser model and in-order checker for the status and
// payload items of the serial frame receiver.
// ----------------------------------------------------------------------------
package sfr_frame_check_pkg;
  import sfr_pkg::*;

  localparam int unsigned PAYLOAD_LEN = FRAME_LEN_DEF - 3;
  localparam int unsigned REPORT_MAX  = 10;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] running_sum;
    logic [IDX_W-1:0]  payload_index;
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_good;
    logic              last;
  } frame_item_t;

  class frame_scoreboard;
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] byte_store [FRAME_LEN_DEF];
    frame_item_t       due_items [$];
    int unsigned       fail_count;
    int unsigned       item_count;

    function new();
      position   = '0;
      sum        = '0;
      fail_count = 0;
      item_count = 0;
      foreach (byte_store[i]) byte_store[i] = '0;
    endfunction

    function void flag(string msg);
      fail_count++;
      if (fail_count <= REPORT_MAX) $display("%0t ERROR %s", $time, msg);
    endfunction

    // advance the parser by one accepted byte and queue the items it causes
    function void note_byte(logic [BYTE_W-1:0] b);
      frame_item_t item;
      logic        good;
      good = 1'b0;
      if (position >= FRAME_LEN_DEF) position = '0;
      if (position == 0) begin
        if (b == HEADER_BYTE) begin
          byte_store[0] = b;
          sum += b;
          position = POS_W'(1);
        end
      end else if (position == 1) begin
        if (b >= TYPE_MIN && b <= TYPE_MAX) begin
          byte_store[1] = b;
          sum += b;
          position = POS_W'(2);
        end else begin
          position = '0;
          sum      = '0;
        end
      end else if (position == FRAME_LEN_DEF - 1) begin
        good     = (b == sum);
        position = '0;
        sum      = '0;
      end else begin
        byte_store[position] = b;
        sum += b;
        position++;
      end
      if (good) begin
        for (int i = 2; i < FRAME_LEN_DEF - 1; i++) begin
          item.kind          = KIND_PAYLOAD;
          item.running_sum   = sum;
          item.payload_index = IDX_W'(i - 2);
          item.payload_byte  = byte_store[i];
          item.frame_good    = 1'b0;
          item.last          = 1'b0;
          due_items.push_back(item);
        end
      end
      item.kind          = KIND_STATUS;
      item.running_sum   = sum;
      item.payload_index = '0;
      item.payload_byte  = '0;
      item.frame_good    = good;
      item.last          = 1'b1;
      due_items.push_back(item);
    endfunction

    function void compare(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
      if (got !== want) begin
        flag($sformatf("item %0d %s: expected %0h, got %0h", item_count, name, want, got));
      end
    endfunction

    function void check_item(frame_item_t got);
      frame_item_t want;
      item_count++;
      if (due_items.size() == 0) begin
        flag($sformatf("item %0d unexpected: kind %0h sum %0h idx %0h byte %0h good %0h last %0h",
                       item_count, got.kind, got.running_sum, got.payload_index,
                       got.payload_byte, got.frame_good, got.last));
        return;
      end
      want = due_items.pop_front();
      compare("kind", BYTE_W'(want.kind), BYTE_W'(got.kind));
      compare("running_sum", want.running_sum, got.running_sum);
      compare("payload_index", BYTE_W'(want.payload_index), BYTE_W'(got.payload_index));
      compare("payload_byte", want.payload_byte, got.payload_byte);
      compare("frame_good", BYTE_W'(want.frame_good), BYTE_W'(got.frame_good));
      compare("last", BYTE_W'(want.last), BYTE_W'(got.last));
    endfunction

    function void flag_leftovers();
      foreach (due_items[i]) begin
        flag($sformatf("missing item: kind %0h sum %0h idx %0h byte %0h good %0h last %0h",
                       due_items[i].kind, due_items[i].running_sum, due_items[i].payload_index,
                       due_items[i].payload_byte, due_items[i].frame_good, due_items[i].last));
      end
    endfunction
  endclass

endpackage

[dv/serial_frame_receiver_sum_check_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_receiver_sum_check_unit_tb
// Feeds noise bytes, good frames, bad types, bad checksums and cut-off frames
// under random idling on both channels; every result item is checked in
// order against a byte-level parser model.
// ----------------------------------------------------------------------------
module serial_frame_receiver_sum_check_unit_tb;
  import sfr_pkg::*;
  import sfr_frame_check_pkg::*;

  localparam int unsigned RANDOM_BYTES = 400;
  localparam int unsigned DRAIN_CYCLES = 2 * FRAME_LEN_DEF + 10;
  localparam int unsigned WAIT_LIMIT   = 200000;

  logic            clk = 1'b0;
  logic            rst;
  logic            quiet = 1'b0;
  int unsigned     framed_bytes = 0;
  frame_scoreboard sb = new();

  sfr_rx_if  rx_ch ();
  sfr_res_if res_ch ();

  serial_frame_receiver_sum_check_unit u_dut (
    .clk(clk),
    .rst(rst),
    .rx (rx_ch),
    .res(res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    sb.note_byte(b);
  endtask

  // sends the first cut bytes of a frame; sum_error offsets the checksum byte
  task automatic send_frame(input logic [BYTE_W-1:0] type_byte,
                            input logic [BYTE_W-1:0] body [PAYLOAD_LEN],
                            input logic [BYTE_W-1:0] sum_error,
                            input int unsigned cut);
    logic [BYTE_W-1:0] frame_bytes [$];
    logic [BYTE_W-1:0] check;
    check = HEADER_BYTE + type_byte;
    frame_bytes.push_back(HEADER_BYTE);
    frame_bytes.push_back(type_byte);
    foreach (body[i]) begin
      check += body[i];
      frame_bytes.push_back(body[i]);
    end
    frame_bytes.push_back(check + sum_error);
    for (int i = 0; i < cut; i++) begin
      send_byte(frame_bytes[i]);
      framed_bytes++;
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] body [PAYLOAD_LEN];
    logic [BYTE_W-1:0] type_byte;
    int unsigned       pick;
    rst           <= 1'b1;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // bytes skipped while hunting for a header
    send_byte(8'h00);
    send_byte(8'hFF);
    // bad type bytes, including a second header
    send_byte(HEADER_BYTE);
    send_byte(8'h00);
    send_byte(HEADER_BYTE);
    send_byte(HEADER_BYTE);
    send_byte(HEADER_BYTE);
    send_byte(TYPE_MAX + 8'd1);
    // good frame with alternating extreme payload
    foreach (body[i]) body[i] = i[0] ? 8'hFF : 8'h00;
    send_frame(TYPE_MIN, body, 8'h00, FRAME_LEN_DEF);
    // wrapping sum, checksum off by one
    foreach (body[i]) body[i] = 8'hFF;
    send_frame(8'h02, body, 8'h01, FRAME_LEN_DEF);
    send_frame(TYPE_MAX, body, 8'h00, FRAME_LEN_DEF);

    framed_bytes = 0;
    while (framed_bytes < RANDOM_BYTES) begin
      quiet = ($urandom_range(0, 3) == 0);
      foreach (body[i]) body[i] = BYTE_W'($urandom_range(0, 255));
      type_byte = BYTE_W'($urandom_range(TYPE_MIN, TYPE_MAX));
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(type_byte, body, 8'h00, FRAME_LEN_DEF);
      end else if (pick < 80) begin
        send_frame(type_byte, body, BYTE_W'($urandom_range(1, 255)), FRAME_LEN_DEF);
      end else if (pick < 87) begin
        type_byte = BYTE_W'($urandom_range(0, 255));
        if (type_byte >= TYPE_MIN && type_byte <= TYPE_MAX) type_byte = type_byte + 8'd4;
        send_frame(type_byte, body, 8'h00, $urandom_range(2, FRAME_LEN_DEF));
      end else if (pick < 92) begin
        send_frame(type_byte, body, 8'h00, $urandom_range(3, FRAME_LEN_DEF - 1));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(0, 255)));
      end
    end
    quiet = 1'b0;
    rx_ch.valid <= 1'b0;

    for (int n = 0; n < WAIT_LIMIT && sb.due_items.size() != 0; n++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.flag_leftovers();
    if (sb.fail_count == 0) begin
      $display("** serial_frame_receiver_sum_check_unit: PASSED **");
    end else begin
      $display("** serial_frame_receiver_sum_check_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    frame_item_t got;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      got.kind          = res_ch.kind;
      got.running_sum   = res_ch.running_sum;
      got.payload_index = res_ch.payload_index;
      got.payload_byte  = res_ch.payload_byte;
      got.frame_good    = res_ch.frame_good;
      got.last          = res_ch.last;
      sb.check_item(got);
    end
  end

  initial begin
    #10_000_000;
    $display("** serial_frame_receiver_sum_check_unit: FAILED **");
    $finish;
  end

endmodule

[sim.f]
hdl/sfr_pkg.sv
hdl/sfr_rx_if.sv
hdl/sfr_res_if.sv
hdl/sfr_ram.sv
hdl/serial_frame_receiver_sum_check_unit.sv
hdl/sfr_checker.sv
dv/sfr_frame_check_pkg.sv
dv/serial_frame_receiver_sum_check_unit_tb.sv
